FILE: rtl/core/ihc_pkg.sv
// Package with the codes, sizes and register map of the IPv4 header checker.
package ihc_pkg;

  // Smallest legal IPv4 header, in bytes.
  localparam logic [5:0] MIN_HEADER_BYTES = 6'd20;

  // IP version that the block accepts.
  localparam logic [3:0] ACCEPTED_IP_VERSION = 4'd4;

  // Configuration register map, indexed by paddr[3:2].
  localparam int unsigned CFG_ADDR_W = 4;
  typedef enum logic [1:0] {
    REG_LOCAL_ADDRESS = 2'd0,
    REG_PROTOCOL_A    = 2'd1,
    REG_PROTOCOL_B    = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_index_t;

  // Verdict codes.
  typedef enum logic [1:0] {
    VERDICT_DROP        = 2'd0,
    VERDICT_DELIVER     = 2'd1,
    VERDICT_UNREACHABLE = 2'd2
  } verdict_t;

  // Drop reason codes.
  typedef enum logic [2:0] {
    REASON_NONE       = 3'd0,
    REASON_SHORT      = 3'd1,
    REASON_VERSION    = 3'd2,
    REASON_LENGTH     = 3'd3,
    REASON_CHECKSUM   = 3'd4,
    REASON_ADDRESS    = 3'd5,
    REASON_HEADER_LEN = 3'd6
  } reason_t;

  // Fixed byte positions inside the header.
  localparam logic [5:0] POS_VERSION    = 6'd0;
  localparam logic [5:0] POS_LEN_HIGH   = 6'd2;
  localparam logic [5:0] POS_LEN_LOW    = 6'd3;
  localparam logic [5:0] POS_PROTOCOL   = 6'd9;
  localparam logic [5:0] POS_CSUM_LOW   = 6'd11;
  localparam logic [5:0] POS_SRC_FIRST  = 6'd12;
  localparam logic [5:0] POS_SRC_LAST   = 6'd15;
  localparam logic [5:0] POS_DST_FIRST  = 6'd16;
  localparam logic [5:0] POS_DST_LAST   = 6'd19;

endpackage

FILE: rtl/core/ihc_if.sv
// Stream interfaces for the packet byte channel and the verdict channel.
interface ihc_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        frame_start;
  logic [15:0] frame_length;

  modport source (output valid, output data_byte, output frame_start,
                  output frame_length, input ready);
  modport sink (input valid, input data_byte, input frame_start,
                input frame_length, output ready);
endinterface

interface ihc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic [2:0]  drop_reason;
  logic [7:0]  protocol;
  logic [31:0] source_address;
  logic [5:0]  header_bytes;
  logic [15:0] payload_length;
  logic [15:0] padding_bytes;

  modport source (output valid, output verdict, output drop_reason,
                  output protocol, output source_address, output header_bytes,
                  output payload_length, output padding_bytes, input ready);
  modport sink (input valid, input verdict, input drop_reason,
                input protocol, input source_address, input header_bytes,
                input payload_length, input padding_bytes, output ready);
endinterface

FILE: rtl/core/ipv4_header_checker_core.sv
// Top level of the IPv4 receive header checker.
//
//   Channel  Direction  Word / access          Handshake
//   in_s     input      one packet byte        valid/ready
//   out_s    output     one verdict per frame  valid/ready
//   cfg      input      APB reads and writes   psel/penable, pready high
//
// Each accepted byte is held in the input register and checked there against
// the running header state; the verdict of the byte that decides it is
// registered for out_s. One byte is accepted every cycle while the output side
// takes results. The running checksum adder and field captures set that rate.
// rst_n is synchronous and clears all control and header state; a stalled
// output holds its verdict while one more byte waits in the input register.
module ipv4_header_checker_core
  import ihc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  ihc_in_if.sink                in_s,
  ihc_out_if.source             out_s,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  // Configuration registers.
  logic [31:0] local_address_r;
  logic [7:0]  protocol_a_r;
  logic [7:0]  protocol_b_r;
  reg_index_t  cfg_index;
  logic        cfg_write;

  // Input register stage.
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_start_r;
  logic [15:0] s1_length_r;

  // Header tracking state.
  logic [5:0]  byte_position_r, byte_position_nxt;
  logic [15:0] frame_bytes_r, frame_bytes_nxt;
  logic [15:0] checksum_sum_r, checksum_sum_nxt;
  logic [7:0]  high_byte_r, high_byte_nxt;
  logic [15:0] stored_checksum_r, stored_checksum_nxt;
  logic [3:0]  ihl_words_r, ihl_words_nxt;
  logic [3:0]  version_r, version_nxt;
  logic [15:0] total_length_r, total_length_nxt;
  logic [7:0]  protocol_r, protocol_nxt;
  logic [31:0] source_r, source_nxt;
  logic [31:0] destination_r, destination_nxt;
  logic        verdict_given_r, verdict_given_nxt;

  // Output register.
  logic        out_valid_r;
  verdict_t    verdict_r, verdict_nxt;
  reason_t     reason_r, reason_nxt;
  logic [7:0]  out_protocol_r, out_protocol_nxt;
  logic [31:0] out_source_r, out_source_nxt;
  logic [5:0]  out_hdr_r, out_hdr_nxt;
  logic [15:0] out_payload_r, out_payload_nxt;
  logic [15:0] out_padding_r, out_padding_nxt;

  logic        advance;
  logic        process;
  logic        in_accept;
  logic        result_valid;
  logic        active;
  logic        decided;
  logic [5:0]  hdr_bytes;
  logic [15:0] word;
  logic [16:0] csum_add;
  logic [15:0] add_operand;

  // APB register port: writes in the access phase, reads from the address.
  assign pready    = 1'b1;
  assign cfg_index = reg_index_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (cfg_index)
      REG_LOCAL_ADDRESS: prdata = local_address_r;
      REG_PROTOCOL_A:    prdata = {24'd0, protocol_a_r};
      REG_PROTOCOL_B:    prdata = {24'd0, protocol_b_r};
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_address_r <= 32'd0;
      protocol_a_r    <= 8'd1;
      protocol_b_r    <= 8'd17;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LOCAL_ADDRESS: local_address_r <= pwdata;
        REG_PROTOCOL_A:    protocol_a_r    <= pwdata[7:0];
        REG_PROTOCOL_B:    protocol_b_r    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Flow control: the check stage moves when the output register is free.
  assign advance    = !out_valid_r || out_s.ready;
  assign process    = s1_valid_r && advance;
  assign in_s.ready = !s1_valid_r || advance;
  assign in_accept  = in_s.valid && in_s.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r   <= in_s.data_byte;
      s1_start_r  <= in_s.frame_start;
      s1_length_r <= in_s.frame_length;
    end
  end

  // Header check for the byte in the input register.
  always_comb begin
    byte_position_nxt   = byte_position_r;
    frame_bytes_nxt     = frame_bytes_r;
    checksum_sum_nxt    = checksum_sum_r;
    high_byte_nxt       = high_byte_r;
    stored_checksum_nxt = stored_checksum_r;
    ihl_words_nxt       = ihl_words_r;
    version_nxt         = version_r;
    total_length_nxt    = total_length_r;
    protocol_nxt        = protocol_r;
    source_nxt          = source_r;
    destination_nxt     = destination_r;
    verdict_given_nxt   = verdict_given_r;
    result_valid        = 1'b0;
    decided             = 1'b0;
    verdict_nxt         = VERDICT_DROP;
    reason_nxt          = REASON_NONE;
    out_protocol_nxt    = 8'd0;
    out_source_nxt      = 32'd0;
    out_hdr_nxt         = 6'd0;
    out_payload_nxt     = 16'd0;
    out_padding_nxt     = 16'd0;
    word                = 16'd0;
    add_operand         = 16'd0;
    csum_add            = 17'd0;
    hdr_bytes           = 6'd0;

    // A frame start clears the header state and opens a new frame.
    if (s1_start_r) begin
      byte_position_nxt   = 6'd0;
      frame_bytes_nxt     = s1_length_r;
      checksum_sum_nxt    = 16'd0;
      high_byte_nxt       = 8'd0;
      stored_checksum_nxt = 16'd0;
      ihl_words_nxt       = 4'd0;
      version_nxt         = 4'd0;
      total_length_nxt    = 16'd0;
      protocol_nxt        = 8'd0;
      source_nxt          = 32'd0;
      destination_nxt     = 32'd0;
      verdict_given_nxt   = 1'b0;
    end
    active = s1_start_r || !verdict_given_r;

    if (active) begin
      byte_position_nxt = byte_position_nxt + 6'd1;

      // First byte: frame size, version and header length checks.
      if (byte_position_r == POS_VERSION || s1_start_r) begin
        version_nxt   = s1_byte_r[7:4];
        ihl_words_nxt = s1_byte_r[3:0];
        if (frame_bytes_nxt < {10'd0, MIN_HEADER_BYTES}) begin
          decided    = 1'b1;
          reason_nxt = REASON_SHORT;
        end else if (version_nxt != ACCEPTED_IP_VERSION) begin
          decided    = 1'b1;
          reason_nxt = REASON_VERSION;
        end else if ({ihl_words_nxt, 2'b00} < MIN_HEADER_BYTES) begin
          decided    = 1'b1;
          reason_nxt = REASON_HEADER_LEN;
        end
      end
      hdr_bytes = {ihl_words_nxt, 2'b00};

      if (!decided) begin
        // Even bytes are held; odd bytes complete a word for the checksum.
        if (!byte_position_r[0] || s1_start_r) begin
          high_byte_nxt = s1_byte_r;
        end else begin
          word = {high_byte_r, s1_byte_r};
          if (byte_position_r == POS_CSUM_LOW) begin
            stored_checksum_nxt = word;
          end else begin
            add_operand = word;
          end
          csum_add         = {1'b0, checksum_sum_nxt} + {1'b0, add_operand};
          checksum_sum_nxt = csum_add[15:0] + {15'd0, csum_add[16]};
        end

        // Field captures and the total length checks.
        if (s1_start_r) begin
          // Header fields never start at the first byte.
        end else if (byte_position_r == POS_LEN_HIGH) begin
          total_length_nxt = {s1_byte_r, 8'd0};
        end else if (byte_position_r == POS_LEN_LOW) begin
          total_length_nxt = {total_length_r[15:8], s1_byte_r};
          if (total_length_nxt > frame_bytes_nxt) begin
            decided    = 1'b1;
            reason_nxt = REASON_LENGTH;
          end else if (total_length_nxt < {10'd0, hdr_bytes}) begin
            decided    = 1'b1;
            reason_nxt = REASON_HEADER_LEN;
          end
        end else if (byte_position_r == POS_PROTOCOL) begin
          protocol_nxt = s1_byte_r;
        end else if (byte_position_r >= POS_SRC_FIRST && byte_position_r <= POS_SRC_LAST) begin
          source_nxt = {source_r[23:0], s1_byte_r};
        end else if (byte_position_r >= POS_DST_FIRST && byte_position_r <= POS_DST_LAST) begin
          destination_nxt = {destination_r[23:0], s1_byte_r};
        end
      end

      // Last header byte: checksum, address and protocol decision.
      if (!decided && !s1_start_r &&
          ({1'b0, byte_position_r} + 7'd1 == {1'b0, hdr_bytes})) begin
        decided = 1'b1;
        if (~checksum_sum_nxt != stored_checksum_nxt) begin
          reason_nxt = REASON_CHECKSUM;
        end else if (destination_nxt != local_address_r) begin
          reason_nxt = REASON_ADDRESS;
        end else begin
          if (protocol_nxt == protocol_a_r || protocol_nxt == protocol_b_r) begin
            verdict_nxt = VERDICT_DELIVER;
          end else begin
            verdict_nxt = VERDICT_UNREACHABLE;
          end
          out_protocol_nxt = protocol_nxt;
          out_source_nxt   = source_nxt;
          out_hdr_nxt      = hdr_bytes;
          out_payload_nxt  = total_length_nxt - {10'd0, hdr_bytes};
          out_padding_nxt  = frame_bytes_nxt - total_length_nxt;
        end
      end

      if (decided) begin
        result_valid      = 1'b1;
        verdict_given_nxt = 1'b1;
      end
    end
  end

  // Header state registers, updated when the check stage moves.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_position_r   <= 6'd0;
      frame_bytes_r     <= 16'd0;
      checksum_sum_r    <= 16'd0;
      high_byte_r       <= 8'd0;
      stored_checksum_r <= 16'd0;
      ihl_words_r       <= 4'd0;
      version_r         <= 4'd0;
      total_length_r    <= 16'd0;
      protocol_r        <= 8'd0;
      source_r          <= 32'd0;
      destination_r     <= 32'd0;
      verdict_given_r   <= 1'b1;
    end else if (process) begin
      byte_position_r   <= byte_position_nxt;
      frame_bytes_r     <= frame_bytes_nxt;
      checksum_sum_r    <= checksum_sum_nxt;
      high_byte_r       <= high_byte_nxt;
      stored_checksum_r <= stored_checksum_nxt;
      ihl_words_r       <= ihl_words_nxt;
      version_r         <= version_nxt;
      total_length_r    <= total_length_nxt;
      protocol_r        <= protocol_nxt;
      source_r          <= source_nxt;
      destination_r     <= destination_nxt;
      verdict_given_r   <= verdict_given_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= process && result_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (process && result_valid) begin
      verdict_r      <= verdict_nxt;
      reason_r       <= reason_nxt;
      out_protocol_r <= out_protocol_nxt;
      out_source_r   <= out_source_nxt;
      out_hdr_r      <= out_hdr_nxt;
      out_payload_r  <= out_payload_nxt;
      out_padding_r  <= out_padding_nxt;
    end
  end

  assign out_s.valid          = out_valid_r;
  assign out_s.verdict        = verdict_r;
  assign out_s.drop_reason    = reason_r;
  assign out_s.protocol       = out_protocol_r;
  assign out_s.source_address = out_source_r;
  assign out_s.header_bytes   = out_hdr_r;
  assign out_s.payload_length = out_payload_r;
  assign out_s.padding_bytes  = out_padding_r;

  // A verdict carries a drop reason exactly when it is a drop.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((verdict_r == VERDICT_DROP) == (reason_r != REASON_NONE)))
    else $error("verdict and drop reason disagree");

  // A delivered or unreachable frame always had a full-size header.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && verdict_r != VERDICT_DROP) |-> (out_hdr_r >= MIN_HEADER_BYTES))
    else $error("non-drop verdict with short header");

  // Once a verdict is produced the frame stays closed.
  assert property (@(posedge clk) disable iff (!rst_n)
    (process && result_valid) |=> verdict_given_r)
    else $error("frame still open after its verdict");

  // A full input register behind a stalled output blocks new bytes.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_s.ready) |-> !in_s.ready)
    else $error("byte accepted while both stages are blocked");

endmodule
